FILE: src/spatial_grid_binning_table_core_defines.svh
// Assertion macros shared by the spatial grid binning table RTL.
`ifndef SPATIAL_GRID_BINNING_TABLE_CORE_DEFINES_SVH
`define SPATIAL_GRID_BINNING_TABLE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked property, disabled while reset is high.
`define SGB_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also active during reset.
`define SGB_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGB_ASSERT(name, clk, rst, prop, msg)
`define SGB_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

FILE: src/sgb_pkg.sv
`default_nettype none
package sgb_pkg;

   // Request function codes.
   localparam logic [1:0] FN_INSERT = 2'd0;
   localparam logic [1:0] FN_CLEAR  = 2'd1;
   localparam logic [1:0] FN_READ   = 2'd2;
   // Spare code; a request carrying it is taken and gives no result.
   localparam logic [1:0] FN_UNUSED = 2'd3;

   // Result status codes.
   localparam logic [1:0] RS_OK    = 2'd0;
   localparam logic [1:0] RS_FULL  = 2'd1;
   localparam logic [1:0] RS_RANGE = 2'd2;
   localparam logic [1:0] RS_EMPTY = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_CELL_SIZE   = 2'd2;

   // Configuration reset values.
   localparam logic [12:0] GRID_WIDTH_RST  = 13'd640;
   localparam logic [12:0] GRID_HEIGHT_RST = 13'd480;
   localparam logic [12:0] CELL_SIZE_RST   = 13'd32;

   // Default table geometry.
   localparam int MAX_BUCKETS_DEF  = 1024;
   localparam int BUCKET_DEPTH_DEF = 8;

   // Width of the divider operands (whole-unit coordinates and cell size).
   localparam int DIV_W = 13;

   // Controller states.
   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DIV_LOAD,
      S_DIV_RUN,
      S_HASH,
      S_APP_RD,
      S_APP_WR,
      S_RD_MEM,
      S_RD_RSP,
      S_CLR,
      S_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_load;
      logic div_run;
      logic hash;
      logic mem_rd;
      logic append;
      logic rd_rsp;
      logic clr_step;
      logic clr_rsp;
      logic next;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic div_last;
      logic hash_last;
      logic clr_last;
      logic rsp_taken;
      logic more;
   } stat_type;

endpackage
`default_nettype wire

FILE: src/sgb_ctrl.sv
`default_nettype none
module sgb_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [1:0]        req_func,
   output logic                   req_stall,
   input  wire sgb_pkg::stat_type stat,
   output sgb_pkg::cmd_type       cmd
);

   sgb_pkg::state_type state_ff, state_in;

   // State register; reset starts the bucket clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgb_pkg::S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sgb_pkg::S_INIT: begin
            if (stat.clr_last) state_in = sgb_pkg::S_IDLE;
         end
         sgb_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  sgb_pkg::FN_INSERT: state_in = sgb_pkg::S_DIV_LOAD;
                  sgb_pkg::FN_CLEAR:  state_in = sgb_pkg::S_CLR;
                  sgb_pkg::FN_READ:   state_in = sgb_pkg::S_RD_MEM;
                  default:            state_in = sgb_pkg::S_IDLE;
               endcase
            end
         end
         sgb_pkg::S_DIV_LOAD: state_in = sgb_pkg::S_DIV_RUN;
         sgb_pkg::S_DIV_RUN: begin
            if (stat.div_done) begin
               state_in = stat.div_last ? sgb_pkg::S_HASH : sgb_pkg::S_DIV_LOAD;
            end
         end
         sgb_pkg::S_HASH: begin
            if (stat.hash_last) state_in = sgb_pkg::S_APP_RD;
         end
         sgb_pkg::S_APP_RD: state_in = sgb_pkg::S_APP_WR;
         sgb_pkg::S_APP_WR: state_in = sgb_pkg::S_OUT;
         sgb_pkg::S_RD_MEM: state_in = sgb_pkg::S_RD_RSP;
         sgb_pkg::S_RD_RSP: state_in = sgb_pkg::S_OUT;
         sgb_pkg::S_CLR: begin
            if (stat.clr_last) state_in = sgb_pkg::S_OUT;
         end
         sgb_pkg::S_OUT: begin
            if (stat.rsp_taken) begin
               state_in = stat.more ? sgb_pkg::S_APP_RD : sgb_pkg::S_IDLE;
            end
         end
         default: state_in = sgb_pkg::S_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         sgb_pkg::S_INIT:     cmd.clr_step = 1'b1;
         sgb_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         sgb_pkg::S_DIV_LOAD: cmd.div_load = 1'b1;
         sgb_pkg::S_DIV_RUN:  cmd.div_run = 1'b1;
         sgb_pkg::S_HASH:     cmd.hash = 1'b1;
         sgb_pkg::S_APP_RD:   cmd.mem_rd = 1'b1;
         sgb_pkg::S_APP_WR:   cmd.append = 1'b1;
         sgb_pkg::S_RD_MEM:   cmd.mem_rd = 1'b1;
         sgb_pkg::S_RD_RSP:   cmd.rd_rsp = 1'b1;
         sgb_pkg::S_CLR: begin
            cmd.clr_step = 1'b1;
            cmd.clr_rsp  = stat.clr_last;
         end
         sgb_pkg::S_OUT:      cmd.next = stat.rsp_taken & stat.more;
         default:             cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

FILE: src/sgb_dp.sv
`default_nettype none
`include "spatial_grid_binning_table_core_defines.svh"
module sgb_dp #(
   parameter int MAX_BUCKETS  = sgb_pkg::MAX_BUCKETS_DEF,
   parameter int BUCKET_DEPTH = sgb_pkg::BUCKET_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [12:0]         csr_wdata,
   input  wire logic [1:0]          req_func,
   input  wire logic [15:0]         req_particle_id,
   input  wire logic signed [19:0]  req_center_x,
   input  wire logic signed [19:0]  req_center_y,
   input  wire logic [15:0]         req_radius,
   input  wire logic [9:0]          req_read_bucket,
   input  wire logic [2:0]          req_read_slot,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [9:0]               rsp_bucket_id,
   output logic [2:0]               rsp_slot,
   output logic [15:0]              rsp_entry_id,
   output logic [3:0]               rsp_bucket_count,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last,
   input  wire sgb_pkg::cmd_type    cmd,
   output sgb_pkg::stat_type        stat
);

   localparam int DW  = sgb_pkg::DIV_W;
   localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int SW  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int FW  = $clog2(BUCKET_DEPTH + 1);
   localparam int XW  = (BW > 10) ? BW : 10;
   localparam int SXW = (SW > 3) ? SW : 3;
   localparam int CW  = 25;
   localparam logic [3:0] DIV_LAST_STEP = 4'(DW - 1);

   // Configuration registers.
   logic [DW-1:0] gw_ff, gh_ff, cs_ff;
   logic [DW-1:0] cs_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff <= sgb_pkg::GRID_WIDTH_RST;
         gh_ff <= sgb_pkg::GRID_HEIGHT_RST;
         cs_ff <= sgb_pkg::CELL_SIZE_RST;
      end else if (csr_we) begin
         case (csr_index)
            sgb_pkg::CSR_GRID_WIDTH:  gw_ff <= csr_wdata;
            sgb_pkg::CSR_GRID_HEIGHT: gh_ff <= csr_wdata;
            sgb_pkg::CSR_CELL_SIZE:   cs_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A zero cell size behaves as one.
   assign cs_eff = (cs_ff == '0) ? DW'(1) : cs_ff;

   // Captured request and bounding-box corners.
   logic [1:0]         func_ff;
   logic [15:0]        id_ff;
   logic signed [21:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic [9:0]         rbkt_ff;
   logic [2:0]         rslot_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         id_ff    <= req_particle_id;
         x0_ff    <= 22'(req_center_x) - $signed({6'd0, req_radius});
         x1_ff    <= 22'(req_center_x) + $signed({6'd0, req_radius});
         y0_ff    <= 22'(req_center_y) - $signed({6'd0, req_radius});
         y1_ff    <= 22'(req_center_y) + $signed({6'd0, req_radius});
         rbkt_ff  <= req_read_bucket;
         rslot_ff <= req_read_slot;
      end
   end

   // Whole-unit coordinate clamped to [0, extent].
   function automatic logic [DW-1:0] axis_num(input logic signed [21:0] c,
                                              input logic [DW-1:0] ext);
      logic [17:0] w;
      w = c[21:4];
      if (c[21]) return '0;
      else if (w > 18'(ext)) return ext;
      else return w[DW-1:0];
   endfunction

   // Shared restoring divider: corners x0, x1, y0, y1, then the column count.
   logic [2:0]    sel_ff;
   logic [3:0]    dcnt_ff;
   logic [DW-1:0] rem_ff, quo_ff;
   logic [DW-1:0] q_ff [0:4];
   logic [DW-1:0] num;
   logic [DW:0]   trial;
   logic          fits;
   logic [DW-1:0] rem_nx, quo_nx;

   always_comb begin
      case (sel_ff)
         3'd0:    num = axis_num(x0_ff, gw_ff);
         3'd1:    num = axis_num(x1_ff, gw_ff);
         3'd2:    num = axis_num(y0_ff, gh_ff);
         3'd3:    num = axis_num(y1_ff, gh_ff);
         default: num = gw_ff;
      endcase
      trial  = {rem_ff, quo_ff[DW-1]};
      fits   = trial >= {1'b0, cs_eff};
      rem_nx = fits ? DW'(trial - {1'b0, cs_eff}) : trial[DW-1:0];
      quo_nx = {quo_ff[DW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.load) begin
         sel_ff <= '0;
      end else if (cmd.div_load) begin
         dcnt_ff <= '0;
      end else if (cmd.div_run) begin
         dcnt_ff <= dcnt_ff + 4'd1;
         if (dcnt_ff == DIV_LAST_STEP) sel_ff <= sel_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= num;
      end else if (cmd.div_run) begin
         rem_ff <= rem_nx;
         quo_ff <= quo_nx;
         if (dcnt_ff == DIV_LAST_STEP) q_ff[sel_ff] <= quo_nx;
      end
   end

   // Cell ids in append order: upper left, bottom right, upper right, bottom left.
   logic [1:0]    hk_ff;
   logic [CW-1:0] cell_ff [0:3];
   logic [DW-1:0] hcol, hrow;

   always_comb begin
      hcol = q_ff[(hk_ff == 2'd1 || hk_ff == 2'd2) ? 3'd1 : 3'd0];
      hrow = q_ff[(hk_ff == 2'd1 || hk_ff == 2'd3) ? 3'd3 : 3'd2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hk_ff <= '0;
      end else if (cmd.load) begin
         hk_ff <= '0;
      end else if (cmd.hash) begin
         hk_ff <= hk_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hash) cell_ff[hk_ff] <= CW'(hcol) + CW'(hrow * q_ff[4]);
   end

   // Number of appends, less one.
   logic [1:0] nlast;
   always_comb begin
      if (cell_ff[0] == cell_ff[1]) nlast = 2'd0;
      else if (cell_ff[0] != cell_ff[3] && cell_ff[0] != cell_ff[2]) nlast = 2'd3;
      else nlast = 2'd1;
   end

   logic [1:0] idx_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.load) begin
         idx_ff <= '0;
      end else if (cmd.next) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   // Clearing sweep over the fill counts.
   logic [BW-1:0] clr_ff;
   logic          clr_last;
   assign clr_last = (32'(clr_ff) == 32'(MAX_BUCKETS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.load) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_last ? '0 : clr_ff + BW'(1);
      end
   end

   // Bucket addressing.
   logic [CW-1:0]  cur_cell;
   logic           cell_ok;
   logic [XW-1:0]  rb_x;
   logic [SXW-1:0] rs_x;
   logic [BW-1:0]  bkt_idx;
   logic           rb_ok;

   always_comb begin
      cur_cell = cell_ff[idx_ff];
      cell_ok  = 32'(cur_cell) < 32'(MAX_BUCKETS);
      rb_x     = XW'(rbkt_ff);
      rs_x     = SXW'(rslot_ff);
      rb_ok    = 32'(rbkt_ff) < 32'(MAX_BUCKETS);
      bkt_idx  = (func_ff == sgb_pkg::FN_READ) ? rb_x[BW-1:0] : cur_cell[BW-1:0];
   end

   // Fill counts and entry store, registered reads.
   logic [FW-1:0] fill_mem [0:MAX_BUCKETS-1];
   logic [15:0]   ent_mem [0:(MAX_BUCKETS << SW)-1];
   logic [FW-1:0] fill_rd_ff;
   logic [15:0]   ent_rd_ff;
   logic          fill_full;
   logic          app_wr;

   assign fill_full = fill_rd_ff >= FW'(BUCKET_DEPTH);
   assign app_wr    = cmd.append & cell_ok & ~fill_full;

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         fill_mem[clr_ff] <= '0;
      end else if (app_wr) begin
         fill_mem[bkt_idx] <= fill_rd_ff + FW'(1);
      end
      if (cmd.mem_rd) fill_rd_ff <= fill_mem[bkt_idx];
   end

   always_ff @(posedge clock) begin
      if (app_wr) ent_mem[{bkt_idx, fill_rd_ff[SW-1:0]}] <= id_ff;
      if (cmd.mem_rd) ent_rd_ff <= ent_mem[{bkt_idx, rs_x[SW-1:0]}];
   end

   // Result register.
   logic       rsp_valid_ff;
   logic [9:0] bkt_out_ff;
   logic [2:0] slot_out_ff;
   logic [15:0] ent_out_ff;
   logic [3:0] cnt_out_ff;
   logic [1:0] sts_out_ff;
   logic       last_out_ff;
   logic       rsp_taken;

   assign rsp_taken = rsp_valid_ff & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.append | cmd.rd_rsp | cmd.clr_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_taken) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         ent_out_ff  <= id_ff;
         last_out_ff <= (idx_ff == nlast);
         if (!cell_ok) begin
            bkt_out_ff  <= '0;
            slot_out_ff <= '0;
            cnt_out_ff  <= '0;
            sts_out_ff  <= sgb_pkg::RS_RANGE;
         end else if (fill_full) begin
            bkt_out_ff  <= cur_cell[9:0];
            slot_out_ff <= '0;
            cnt_out_ff  <= 4'(fill_rd_ff);
            sts_out_ff  <= sgb_pkg::RS_FULL;
         end else begin
            bkt_out_ff  <= cur_cell[9:0];
            slot_out_ff <= 3'(fill_rd_ff);
            cnt_out_ff  <= 4'(fill_rd_ff + FW'(1));
            sts_out_ff  <= sgb_pkg::RS_OK;
         end
      end else if (cmd.rd_rsp) begin
         bkt_out_ff  <= rbkt_ff;
         slot_out_ff <= rslot_ff;
         last_out_ff <= 1'b1;
         if (!rb_ok) begin
            ent_out_ff <= '0;
            cnt_out_ff <= '0;
            sts_out_ff <= sgb_pkg::RS_RANGE;
         end else if (8'(rslot_ff) >= 8'(fill_rd_ff)) begin
            ent_out_ff <= '0;
            cnt_out_ff <= 4'(fill_rd_ff);
            sts_out_ff <= sgb_pkg::RS_EMPTY;
         end else begin
            ent_out_ff <= ent_rd_ff;
            cnt_out_ff <= 4'(fill_rd_ff);
            sts_out_ff <= sgb_pkg::RS_OK;
         end
      end else if (cmd.clr_rsp) begin
         bkt_out_ff  <= '0;
         slot_out_ff <= '0;
         ent_out_ff  <= '0;
         cnt_out_ff  <= '0;
         sts_out_ff  <= sgb_pkg::RS_OK;
         last_out_ff <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bucket_id    = bkt_out_ff;
   assign rsp_slot         = slot_out_ff;
   assign rsp_entry_id     = ent_out_ff;
   assign rsp_bucket_count = cnt_out_ff;
   assign rsp_status       = sts_out_ff;
   assign rsp_last         = last_out_ff;

   // Status to the controller.
   always_comb begin
      stat.div_done  = cmd.div_run & (dcnt_ff == DIV_LAST_STEP);
      stat.div_last  = (sel_ff == 3'd4);
      stat.hash_last = (hk_ff == 2'd3);
      stat.clr_last  = clr_last;
      stat.rsp_taken = rsp_taken;
      stat.more      = (func_ff == sgb_pkg::FN_INSERT) & (idx_ff != nlast);
   end

   // A new result never overwrites one still waiting.
   `SGB_ASSERT(a_no_overwrite, clock, reset,
      (cmd.append || cmd.rd_rsp || cmd.clr_rsp) |-> !rsp_valid_ff,
      "result overwritten while pending")
   // The divider walks at most the five operands.
   `SGB_ASSERT(a_sel_range, clock, reset, sel_ff <= 3'd5, "divider operand index overrun")
   // Appends stay within the planned corner list.
   `SGB_ASSERT(a_idx_range, clock, reset, cmd.append |-> idx_ff <= nlast,
      "append beyond planned corner count")
   // Stepping to the next corner only follows a taken result.
   `SGB_ASSERT(a_next_taken, clock, reset, cmd.next |-> rsp_taken,
      "corner advance without result handoff")

endmodule
`default_nettype wire

FILE: src/spatial_grid_binning_table_core.sv
`default_nettype none
// Uniform-grid binning table. An insert request clamps the four corners of a particle's
// bounding box to the world, divides each by the cell size on one shared 13-step
// restoring divider (plus one more division for the column count), forms the cell ids
// with one multiply per cycle and appends the id to one, two or four buckets, one result
// each. An insert runs the divider and hashing, then per append reads the fill count
// and writes the entry; a read fetches the fill count and entry; a clear sweeps the
// fill counts one bucket per cycle, and the same sweep runs after reset before the
// first request is taken. Configuration writes are taken at any time the block is idle.
module spatial_grid_binning_table_core #(
   parameter int MAX_BUCKETS  = sgb_pkg::MAX_BUCKETS_DEF,
   parameter int BUCKET_DEPTH = sgb_pkg::BUCKET_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [12:0]        csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_func,
   input  wire logic [15:0]        req_particle_id,
   input  wire logic signed [19:0] req_center_x,
   input  wire logic signed [19:0] req_center_y,
   input  wire logic [15:0]        req_radius,
   input  wire logic [9:0]         req_read_bucket,
   input  wire logic [2:0]         req_read_slot,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [9:0]              rsp_bucket_id,
   output logic [2:0]              rsp_slot,
   output logic [15:0]             rsp_entry_id,
   output logic [3:0]              rsp_bucket_count,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last
);

   sgb_pkg::cmd_type  cmd;
   sgb_pkg::stat_type stat;

   // Sequencer.
   sgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Divider, hashing, bucket memories and result register.
   sgb_dp #(
      .MAX_BUCKETS  (MAX_BUCKETS),
      .BUCKET_DEPTH (BUCKET_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_func         (req_func),
      .req_particle_id  (req_particle_id),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius       (req_radius),
      .req_read_bucket  (req_read_bucket),
      .req_read_slot    (req_read_slot),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bucket_id    (rsp_bucket_id),
      .rsp_slot         (rsp_slot),
      .rsp_entry_id     (rsp_entry_id),
      .rsp_bucket_count (rsp_bucket_count),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule
`default_nettype wire
